[design/nfbia_pkg.sv]
// shared command and status codes for the next-fit id allocator
`default_nettype none

package nfbia_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTALLOC = 2'd3
  } status_t;

endpackage

`default_nettype wire

[design/next_fit_bitmap_id_allocator.sv]
// next-fit bitmap id allocator: input register, one-pass command logic, result register
//
//  channel   ports                                  handshake
//  --------  -------------------------------------  -------------------------------
//  command   start, busy, cmd, id_in                beat taken when start && !busy
//  result    done, status, id_out, active,          beat shown for one cycle while
//            slot_index                             done is high, cannot be held off
//
// a command is registered at acceptance in the input register, and its result is
// registered in the result register, where done goes high
// one command can be taken every cycle while busy is low: the bitmap and search start
// are updated in the same cycle as the result register, so the next command sees them
// the free-slot search is a rotated priority encoder over the NUM_IDS-bit map
// busy is high for one cycle after each reset cycle; reset empties the map
// there is no backpressure on results
`default_nettype none

module next_fit_bitmap_id_allocator #(
  parameter int unsigned NUM_IDS = 8,
  parameter int unsigned ID_BASE = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [nfbia_pkg::CMD_W-1:0]    cmd,
  input  wire logic [nfbia_pkg::ID_W-1:0]     id_in,
  output logic                                done,
  output logic [nfbia_pkg::STATUS_W-1:0]      status,
  output logic [nfbia_pkg::ID_W-1:0]          id_out,
  output logic                                active,
  output logic [nfbia_pkg::SLOT_W-1:0]        slot_index
);

  localparam int unsigned SW   = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int unsigned OFFW = nfbia_pkg::ID_W + 1;
  localparam logic [OFFW-1:0] BASE_X  = OFFW'(ID_BASE);
  localparam logic [OFFW-1:0] LIMIT_X = OFFW'(ID_BASE + NUM_IDS);

  // lowest set bit of a slot vector
  function automatic logic [SW-1:0] lowest_set(input logic [NUM_IDS-1:0] v);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (v[i]) idx = SW'(i);
    end
    return idx;
  endfunction

  logic                   in_valid;
  nfbia_pkg::cmd_t        cmd_q;
  logic [nfbia_pkg::ID_W-1:0] id_q;

  logic [NUM_IDS-1:0]     used_map;
  logic [NUM_IDS-1:0]     used_map_next;
  logic [SW-1:0]          search_start;
  logic [SW-1:0]          search_start_next;

  logic [NUM_IDS-1:0]     free_map;
  logic [NUM_IDS-1:0]     upper_free;
  logic [SW-1:0]          pick;
  logic [OFFW-1:0]        id_x;
  logic [OFFW-1:0]        id_off;
  logic                   in_range;
  logic [SW-1:0]          id_slot;
  logic                   id_used;

  nfbia_pkg::status_t     status_next;
  logic [nfbia_pkg::ID_W-1:0] id_out_next;
  logic                   active_next;
  logic [SW-1:0]          slot_next;

  always_ff @(posedge clk) begin
    busy <= rst;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      cmd_q <= nfbia_pkg::cmd_t'(cmd);
      id_q  <= id_in;
    end
  end

  // search window: free slots at or above the search start, else wrap
  assign free_map   = ~used_map;
  assign upper_free = free_map & ({NUM_IDS{1'b1}} << search_start);
  assign pick       = (|upper_free) ? lowest_set(upper_free) : lowest_set(free_map);

  assign id_x     = {1'b0, id_q};
  assign in_range = (id_x >= BASE_X) && (id_x < LIMIT_X);
  assign id_off   = id_x - BASE_X;
  assign id_slot  = id_off[SW-1:0];
  assign id_used  = used_map[id_slot];

  always_comb begin
    used_map_next     = used_map;
    search_start_next = search_start;
    status_next       = nfbia_pkg::ST_OK;
    id_out_next       = '0;
    active_next       = 1'b0;
    slot_next         = '0;
    unique case (cmd_q)
      nfbia_pkg::CMD_ALLOC: begin
        if (|free_map) begin
          used_map_next[pick] = 1'b1;
          search_start_next   = pick;
          slot_next           = pick;
          id_out_next         = nfbia_pkg::ID_W'(ID_BASE) + nfbia_pkg::ID_W'(pick);
        end else begin
          status_next = nfbia_pkg::ST_FULL;
        end
      end
      nfbia_pkg::CMD_CLEAR: begin
        used_map_next     = '0;
        search_start_next = '0;
      end
      nfbia_pkg::CMD_RELEASE: begin
        if (!in_range) begin
          status_next = nfbia_pkg::ST_RANGE;
        end else begin
          slot_next = id_slot;
          if (id_used) used_map_next[id_slot] = 1'b0;
          else         status_next = nfbia_pkg::ST_NOTALLOC;
        end
      end
      nfbia_pkg::CMD_QUERY: begin
        if (!in_range) begin
          status_next = nfbia_pkg::ST_RANGE;
        end else begin
          slot_next   = id_slot;
          active_next = id_used;
        end
      end
      default: begin
        status_next = nfbia_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map     <= '0;
      search_start <= '0;
      done         <= 1'b0;
    end else begin
      done <= in_valid;
      if (in_valid) begin
        used_map     <= used_map_next;
        search_start <= search_start_next;
      end
    end
    if (in_valid) begin
      status     <= status_next;
      id_out     <= id_out_next;
      active     <= active_next;
      slot_index <= nfbia_pkg::SLOT_W'(slot_next);
    end
  end

  // every accepted beat gives exactly one result, through the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted command gave no result");

  // a full report only when every slot is taken
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == nfbia_pkg::ST_FULL) |-> (&used_map))
    else $error("full reported with a free slot");

  // an active query is always reported ok
  a_active_ok: assert property (@(posedge clk) disable iff (rst)
    (done && active) |-> (status == nfbia_pkg::ST_OK))
    else $error("active set on a failed command");

  // search start stays inside the map
  a_start_range: assert property (@(posedge clk) disable iff (rst)
    (32'(search_start) < NUM_IDS))
    else $error("search start beyond the map");

endmodule

`default_nettype wire

[tb/id_alloc_checker.sv]
`timescale 1ns / 100ps
// result checker for the next-fit id allocator: tracks the slot map and compares every result beat
module id_alloc_checker #(
  parameter int unsigned NUM_IDS = 8,
  parameter int unsigned ID_BASE = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic [nfbia_pkg::CMD_W-1:0]    cmd,
  input  wire logic [nfbia_pkg::ID_W-1:0]     id_in,
  input  wire logic                           done,
  input  wire logic [nfbia_pkg::STATUS_W-1:0] status,
  input  wire logic [nfbia_pkg::ID_W-1:0]     id_out,
  input  wire logic                           active,
  input  wire logic [nfbia_pkg::SLOT_W-1:0]   slot_index,
  output int unsigned                         error_count,
  output int unsigned                         outstanding
);

  typedef struct packed {
    nfbia_pkg::status_t           status;
    logic [nfbia_pkg::ID_W-1:0]   id_out;
    logic                         active;
    logic [nfbia_pkg::SLOT_W-1:0] slot;
  } alloc_result_t;

  logic [NUM_IDS-1:0] slot_taken;
  int unsigned        next_search;
  alloc_result_t      pending_results[$];
  int unsigned        mismatches;

  function automatic alloc_result_t apply_command(nfbia_pkg::cmd_t c,
                                                  logic [nfbia_pkg::ID_W-1:0] id);
    alloc_result_t r;
    int            found;
    int            s;
    r = '0;
    r.status = nfbia_pkg::ST_OK;
    found = -1;
    case (c)
      nfbia_pkg::CMD_ALLOC: begin
        for (s = next_search; s < NUM_IDS; s++)
          if (found < 0 && !slot_taken[s]) found = s;
        // nothing free above the search start: wrap to the lowest free slot
        for (s = 0; s < NUM_IDS; s++)
          if (found < 0 && !slot_taken[s]) found = s;
        if (found < 0) begin
          r.status = nfbia_pkg::ST_FULL;
        end else begin
          slot_taken[found] = 1'b1;
          next_search = found;
          r.id_out = nfbia_pkg::ID_W'(ID_BASE + found);
          r.slot = nfbia_pkg::SLOT_W'(found);
        end
      end
      nfbia_pkg::CMD_CLEAR: begin
        slot_taken = '0;
        next_search = 0;
      end
      default: begin
        if (int'(id) < int'(ID_BASE) || int'(id) >= int'(ID_BASE + NUM_IDS)) begin
          r.status = nfbia_pkg::ST_RANGE;
        end else begin
          s = int'(id) - int'(ID_BASE);
          r.slot = nfbia_pkg::SLOT_W'(s);
          if (c == nfbia_pkg::CMD_RELEASE) begin
            if (!slot_taken[s]) r.status = nfbia_pkg::ST_NOTALLOC;
            else slot_taken[s] = 1'b0;
          end else begin
            r.active = slot_taken[s];
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst) begin
      slot_taken = '0;
      next_search = 0;
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        got = '{nfbia_pkg::status_t'(status), id_out, active, slot_index};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat: status %0d id %0d active %0d slot %0d",
                     $time, got.status, got.id_out, got.active, got.slot);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.id_out !== want.id_out ||
              got.active !== want.active || got.slot !== want.slot) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch: want status %0d id %0d active %0d slot %0d,",
                        " got status %0d id %0d active %0d slot %0d"}, $time,
                       want.status, want.id_out, want.active, want.slot,
                       got.status, got.id_out, got.active, got.slot);
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(apply_command(nfbia_pkg::cmd_t'(cmd), id_in));
    end
    error_count <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

[tb/next_fit_bitmap_id_allocator_test.sv]
`timescale 1ns / 100ps
// stimulus and verdict for the next-fit id allocator
module next_fit_bitmap_id_allocator_test;

  localparam int unsigned NUM_IDS      = 8;
  localparam int unsigned ID_BASE      = 2;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned QUIET_TAIL   = 80;
  localparam int unsigned STALL_LIMIT  = 1000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic [nfbia_pkg::CMD_W-1:0]    cmd = '0;
  logic [nfbia_pkg::ID_W-1:0]     id_in = '0;
  logic                           busy;
  logic                           done;
  logic [nfbia_pkg::STATUS_W-1:0] status;
  logic [nfbia_pkg::ID_W-1:0]     id_out;
  logic                           active;
  logic [nfbia_pkg::SLOT_W-1:0]   slot_index;
  int unsigned                    error_count;
  int unsigned                    outstanding;
  int unsigned                    quiet_cycles = 0;

  next_fit_bitmap_id_allocator #(.NUM_IDS(NUM_IDS), .ID_BASE(ID_BASE)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .id_in(id_in),
    .done(done), .status(status), .id_out(id_out), .active(active),
    .slot_index(slot_index)
  );

  id_alloc_checker #(.NUM_IDS(NUM_IDS), .ID_BASE(ID_BASE)) checker_inst (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .id_in(id_in),
    .done(done), .status(status), .id_out(id_out), .active(active),
    .slot_index(slot_index), .error_count(error_count), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: any accepted command or result beat restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // drive one command beat and hold it until taken; returns at a falling edge
  task automatic send_command(nfbia_pkg::cmd_t c, logic [nfbia_pkg::ID_W-1:0] id);
    start <= 1'b1;
    cmd <= c;
    id_in <= id;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic maybe_pause(int unsigned odds);
    if (odds != 0 && $urandom_range(0, odds) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  initial begin
    int unsigned                roll;
    int unsigned                pause_odds;
    nfbia_pkg::cmd_t            c;
    logic [nfbia_pkg::ID_W-1:0] id;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: range edges, free-slot release and query, fill, full, wrap, clear
    send_command(nfbia_pkg::CMD_QUERY, 8'd0);
    send_command(nfbia_pkg::CMD_QUERY, 8'd255);
    send_command(nfbia_pkg::CMD_QUERY, nfbia_pkg::ID_W'(ID_BASE));
    send_command(nfbia_pkg::CMD_RELEASE, nfbia_pkg::ID_W'(ID_BASE));
    send_command(nfbia_pkg::CMD_RELEASE, nfbia_pkg::ID_W'(ID_BASE + NUM_IDS - 1));
    send_command(nfbia_pkg::CMD_RELEASE, nfbia_pkg::ID_W'(ID_BASE + NUM_IDS));
    send_command(nfbia_pkg::CMD_RELEASE, nfbia_pkg::ID_W'(ID_BASE - 1));
    repeat (NUM_IDS) send_command(nfbia_pkg::CMD_ALLOC, 8'd255);
    send_command(nfbia_pkg::CMD_ALLOC, 8'd0);
    send_command(nfbia_pkg::CMD_QUERY, nfbia_pkg::ID_W'(ID_BASE + 3));
    send_command(nfbia_pkg::CMD_RELEASE, nfbia_pkg::ID_W'(ID_BASE + 3));
    send_command(nfbia_pkg::CMD_ALLOC, 8'd0);
    send_command(nfbia_pkg::CMD_RELEASE, nfbia_pkg::ID_W'(ID_BASE + 1));
    send_command(nfbia_pkg::CMD_RELEASE, nfbia_pkg::ID_W'(ID_BASE + 2));
    send_command(nfbia_pkg::CMD_ALLOC, 8'd0);
    send_command(nfbia_pkg::CMD_CLEAR, 8'd255);
    send_command(nfbia_pkg::CMD_QUERY, nfbia_pkg::ID_W'(ID_BASE + NUM_IDS - 1));
    send_command(nfbia_pkg::CMD_ALLOC, 8'd0);

    pause_odds = 3;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // idle density changes in phases, including stretches with none
      if (i % 50 == 0) pause_odds = $urandom_range(0, 4);
      if (i >= RANDOM_ITEMS - QUIET_TAIL) pause_odds = 0;
      roll = $urandom_range(0, 99);
      if (roll < 42) c = nfbia_pkg::CMD_ALLOC;
      else if (roll < 72) c = nfbia_pkg::CMD_RELEASE;
      else if (roll < 96) c = nfbia_pkg::CMD_QUERY;
      else c = nfbia_pkg::CMD_CLEAR;
      if ($urandom_range(0, 99) < 85)
        id = nfbia_pkg::ID_W'(ID_BASE + $urandom_range(0, NUM_IDS - 1));
      else
        id = nfbia_pkg::ID_W'($urandom_range(0, 255));
      maybe_pause(pause_odds);
      send_command(c, id);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/nfbia_pkg.sv
design/next_fit_bitmap_id_allocator.sv
tb/id_alloc_checker.sv
tb/next_fit_bitmap_id_allocator_test.sv
